// ----- rtl/core/huffman_code_bit_packer_defines.svh -----
// Assertion macros for the Huffman code bit packer.
// Used by the RTL modules that check their own control logic; needs clk_i and rst_ni in scope.
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define HCBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hcbp assertion failed");

// Check that a condition in one cycle implies another in the next.
`define HCBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcbp assertion failed");

`endif

// ----- rtl/core/hcbp_pkg.sv -----
// Package of the Huffman code bit packer: field widths, opcodes, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int unsigned OpW        = 2;
  localparam int unsigned SymW       = 8;
  localparam int unsigned CodeW      = 32;
  localparam int unsigned LenW       = 6;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = 1;
  localparam int unsigned QCntW      = 2;

  typedef enum logic [OpW-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_ENCODE
  } bstate_e;

  typedef struct packed {
    logic             flush;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } job_t;

endpackage

`default_nettype wire

// ----- rtl/core/hcbp_ifs.sv -----
// Request and result channel interfaces of the Huffman code bit packer.
// Depends on hcbp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hcbp_in_if;
  logic                         valid;
  logic                         ready;
  logic [hcbp_pkg::OpW-1:0]     opcode;
  logic [hcbp_pkg::SymW-1:0]    symbol;
  logic [hcbp_pkg::CodeW-1:0]   code_bits;
  logic [hcbp_pkg::LenW-1:0]    code_length;

  modport source(output valid, output opcode, output symbol, output code_bits,
                 output code_length, input ready);
  modport sink(input valid, input opcode, input symbol, input code_bits,
               input code_length, output ready);
endinterface

interface hcbp_out_if;
  logic                         valid;
  logic                         ready;
  logic [hcbp_pkg::ByteW-1:0]   out_byte;
  logic                         last;

  modport source(output valid, output out_byte, output last, input ready);
  modport sink(input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hcbp_front.sv -----
// Front end: accepts requests, keeps the code and length tables, classifies items.
// Depends on hcbp_pkg and hcbp_in_if; feeds encode and flush jobs to the queue.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_front #(
  parameter int unsigned MaxCodeLen = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  hcbp_in_if.sink         in_i,
  output logic            job_valid_o,
  output hcbp_pkg::job_t  job_o,
  input  logic            job_ready_i
);

  localparam int unsigned Depth = 1 << hcbp_pkg::SymW;
  localparam logic [hcbp_pkg::LenW-1:0] MaxLen = hcbp_pkg::LenW'(MaxCodeLen);

  logic [hcbp_pkg::CodeW-1:0] code_mem [Depth];
  logic [hcbp_pkg::LenW-1:0]  len_mem  [Depth];
  logic [Depth-1:0]           vld_q;

  logic                       s1_v_q, s1_v_d;
  logic                       s1_flush_q;
  logic [hcbp_pkg::CodeW-1:0] code_rd_q;
  logic [hcbp_pkg::LenW-1:0]  len_rd_q;
  logic                       vld_rd_q;

  logic                       accept;
  logic                       is_load, is_enc, is_flush;
  logic [hcbp_pkg::LenW-1:0]  len_sat, len_eff;
  logic                       drop, s1_go;

  assign is_load  = (in_i.opcode == hcbp_pkg::OP_LOAD);
  assign is_enc   = (in_i.opcode == hcbp_pkg::OP_ENCODE);
  assign is_flush = (in_i.opcode == hcbp_pkg::OP_FLUSH);
  assign len_sat  = (in_i.code_length > MaxLen) ? MaxLen : in_i.code_length;

  assign len_eff     = vld_rd_q ? len_rd_q : '0;
  assign drop        = !s1_flush_q && (len_eff == '0);
  assign s1_go       = drop || job_ready_i;
  assign in_i.ready  = !s1_v_q || s1_go;
  assign accept      = in_i.valid && in_i.ready;

  assign job_valid_o = s1_v_q && !drop;
  assign job_o.flush = s1_flush_q;
  assign job_o.code  = code_rd_q;
  assign job_o.len   = len_eff;

  always_comb begin
    s1_v_d = s1_v_q && !s1_go;
    if (accept) begin
      s1_v_d = is_enc || is_flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      vld_q  <= '0;
    end else begin
      s1_v_q <= s1_v_d;
      if (accept && is_load) begin
        vld_q[in_i.symbol] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flush_q <= is_flush;
      if (is_enc) begin
        code_rd_q <= code_mem[in_i.symbol];
        len_rd_q  <= len_mem[in_i.symbol];
        vld_rd_q  <= vld_q[in_i.symbol];
      end
      if (is_load) begin
        code_mem[in_i.symbol] <= in_i.code_bits;
        len_mem[in_i.symbol]  <= len_sat;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hcbp_queue.sv -----
// Two-entry job queue between the front end and the bit packer.
// Depends on hcbp_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_code_bit_packer_defines.svh"

module hcbp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hcbp_pkg::job_t  data_i,
  output logic            ready_o,
  output logic            valid_o,
  input  logic            pop_i,
  output hcbp_pkg::job_t  data_o
);

  hcbp_pkg::job_t                 mem_q [hcbp_pkg::QueueDepth];
  logic [hcbp_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [hcbp_pkg::QCntW-1:0]     cnt_q;
  logic                           do_push;

  assign ready_o = (cnt_q != hcbp_pkg::QCntW'(hcbp_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({do_push, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `HCBP_ASSERT(a_cnt_range, cnt_q <= hcbp_pkg::QCntW'(hcbp_pkg::QueueDepth))
  `HCBP_ASSERT(a_no_empty_pop, pop_i |-> (cnt_q != '0))

endmodule

`default_nettype wire

// ----- rtl/core/hcbp_back.sv -----
// Bit packer: takes jobs from the queue, packs code bits MSB-first into bytes.
// Depends on hcbp_pkg and hcbp_out_if; holds the accumulator and the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_code_bit_packer_defines.svh"

module hcbp_back #(
  parameter int unsigned MaxCodeLen = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  hcbp_pkg::job_t  job_i,
  output logic            pop_o,
  hcbp_out_if.source      out_o
);

  localparam int unsigned SW = MaxCodeLen + hcbp_pkg::ByteW;
  localparam logic [hcbp_pkg::LenW-1:0] MaxLen = hcbp_pkg::LenW'(MaxCodeLen);

  hcbp_pkg::bstate_e          st_q, st_d;
  logic [SW-1:0]              sh_q, sh_d;
  logic [hcbp_pkg::LenW-1:0]  rem_q, rem_d;
  logic [7:0]                 acc_q, acc_d;
  logic [2:0]                 fill_q, fill_d;
  logic                       out_v_q, out_v_d;
  logic [7:0]                 out_byte_q, out_byte_d;
  logic                       out_last_q, out_last_d;

  logic [63:0]                code_wide;
  logic [MaxCodeLen-1:0]      code_ext;
  logic [SW-1:0]              base, sh_load;
  logic [hcbp_pkg::LenW-1:0]  shamt, rem_after;
  logic [3:0]                 avail, take, fill_sum;
  logic [7:0]                 top8, step_byte;
  logic                       out_free, pop_flush;

  assign code_wide = {32'b0, job_i.code};
  assign code_ext  = code_wide[MaxCodeLen-1:0];
  assign base      = {code_ext, 8'h00};
  assign shamt     = MaxLen - job_i.len;
  assign sh_load   = base << shamt;

  assign avail     = 4'd8 - {1'b0, fill_q};
  assign take      = (rem_q < {2'b00, avail}) ? rem_q[3:0] : avail;
  assign rem_after = rem_q - {2'b00, take};
  assign fill_sum  = {1'b0, fill_q} + take;
  assign top8      = sh_q[SW-1 -: 8];
  assign step_byte = acc_q | (top8 >> fill_q);

  assign out_free  = !out_v_q || out_o.ready;
  assign pop_flush = pop_o && job_i.flush;

  assign out_o.valid    = out_v_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = out_last_q;

  always_comb begin
    st_d       = st_q;
    sh_d       = sh_q;
    rem_d      = rem_q;
    acc_d      = acc_q;
    fill_d     = fill_q;
    out_v_d    = out_v_q && !out_o.ready;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    pop_o      = 1'b0;
    case (st_q)
      hcbp_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          if (job_i.flush) begin
            if (out_free) begin
              pop_o      = 1'b1;
              out_v_d    = 1'b1;
              out_byte_d = acc_q;
              out_last_d = 1'b1;
              acc_d      = '0;
              fill_d     = '0;
            end
          end else begin
            pop_o = 1'b1;
            sh_d  = sh_load;
            rem_d = job_i.len;
            st_d  = hcbp_pkg::ST_ENCODE;
          end
        end
      end
      hcbp_pkg::ST_ENCODE: begin
        if (out_free) begin
          sh_d  = sh_q << take;
          rem_d = rem_after;
          if (fill_sum[3]) begin
            out_v_d    = 1'b1;
            out_byte_d = step_byte;
            out_last_d = (rem_after < hcbp_pkg::LenW'(8));
            acc_d      = '0;
            fill_d     = '0;
          end else begin
            acc_d  = step_byte;
            fill_d = fill_sum[2:0];
          end
          if (rem_after == '0) begin
            st_d = hcbp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        st_d = hcbp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= hcbp_pkg::ST_IDLE;
      rem_q   <= '0;
      acc_q   <= '0;
      fill_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      rem_q   <= rem_d;
      acc_q   <= acc_d;
      fill_q  <= fill_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q       <= sh_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  `HCBP_ASSERT(a_enc_has_bits, (st_q == hcbp_pkg::ST_ENCODE) |-> (rem_q != '0))
  `HCBP_ASSERT_NEXT(a_flush_emits, pop_flush, out_v_q && out_last_q && (fill_q == '0))

endmodule

`default_nettype wire

// ----- rtl/core/huffman_code_bit_packer.sv -----
// A request passes the front-end stage register and the job queue; a flush then loads the
// output register, while an encode enters the packer's encode state before its first byte.
// The packer forms one byte per cycle while the result channel is not stalled; up to two jobs queue.
// Reset: asynchronous, active low; clears the length table valid bits, the accumulator,
// the queue and all handshake state. The code table is not reset.
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer #(
  parameter int unsigned MaxCodeLen = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcbp_in_if.sink     in_i,
  hcbp_out_if.source  out_o
);

  logic            push, q_ready, q_valid, pop;
  hcbp_pkg::job_t  push_job, head_job;

  hcbp_front #(
    .MaxCodeLen(MaxCodeLen)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .job_valid_o(push),
    .job_o      (push_job),
    .job_ready_i(q_ready)
  );

  hcbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .pop_i  (pop),
    .data_o (head_job)
  );

  hcbp_back #(
    .MaxCodeLen(MaxCodeLen)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (head_job),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench of huffman_code_bit_packer: code table loads, encodes and flushes.
// Needs hcbp_pkg and the channel interfaces in hcbp_ifs.sv; predicts every packed byte itself.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MaxCodeLen = 32;
  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 24;

  typedef struct packed {
    logic [hcbp_pkg::ByteW-1:0] out_byte;
    logic                       last;
  } packed_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hcbp_in_if  req_if ();
  hcbp_out_if byte_if ();

  huffman_code_bit_packer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (byte_if)
  );

  always #5 clk_i = ~clk_i;

  logic [hcbp_pkg::CodeW-1:0] code_shadow [256];
  logic [hcbp_pkg::LenW-1:0]  len_table  [256];
  logic [hcbp_pkg::ByteW-1:0] acc_byte;
  int                         acc_fill;
  packed_byte_t               pending_bytes [$];
  logic [hcbp_pkg::SymW-1:0]  alphabet [16];

  int   error_cnt;
  int   idle_cycles;
  int   hold_cycles_left;
  logic stall_enable;
  bit   gap_enable;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    error_cnt++;
  endtask

  task automatic predict_packing(input hcbp_pkg::op_e op,
                                 input logic [hcbp_pkg::SymW-1:0] sym,
                                 input logic [hcbp_pkg::CodeW-1:0] bits,
                                 input logic [hcbp_pkg::LenW-1:0] len);
    logic b;
    case (op)
      hcbp_pkg::OP_LOAD: begin
        code_shadow[sym] = bits;
        len_table[sym]   = (len > MaxCodeLen) ? hcbp_pkg::LenW'(MaxCodeLen) : len;
      end
      hcbp_pkg::OP_ENCODE: begin
        for (int i = int'(len_table[sym]); i > 0; i--) begin
          b = (i - 1 < hcbp_pkg::CodeW) ? code_shadow[sym][i-1] : 1'b0;
          acc_byte[7-acc_fill] = b;
          acc_fill++;
          if (acc_fill == 8) begin
            pending_bytes.push_back(packed_byte_t'{acc_byte, (i - 1) < 8});
            acc_byte = '0;
            acc_fill = 0;
          end
        end
      end
      hcbp_pkg::OP_FLUSH: begin
        pending_bytes.push_back(packed_byte_t'{acc_byte, 1'b1});
        acc_byte = '0;
        acc_fill = 0;
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input hcbp_pkg::op_e op,
                              input logic [hcbp_pkg::SymW-1:0] sym,
                              input logic [hcbp_pkg::CodeW-1:0] bits,
                              input logic [hcbp_pkg::LenW-1:0] len);
    while (gap_enable && $urandom_range(99) < 19) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.symbol      <= sym;
    req_if.code_bits   <= bits;
    req_if.code_length <= len;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_packing(op, sym, bits, len);
  endtask

  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [hcbp_pkg::LenW-1:0] random_code_length();
    int r;
    r = $urandom_range(99);
    if (r < 70) return hcbp_pkg::LenW'($urandom_range(1, 12));
    if (r < 88) return hcbp_pkg::LenW'($urandom_range(13, 32));
    if (r < 96) return hcbp_pkg::LenW'($urandom_range(33, 63));
    return '0;
  endfunction

  task automatic load_alphabet();
    for (int i = 0; i < 16; i++) begin
      alphabet[i] = hcbp_pkg::SymW'($urandom_range(255));
      send_request(hcbp_pkg::OP_LOAD, alphabet[i], $urandom, random_code_length());
    end
  endtask

  task automatic send_random_request(input bit allow_noise);
    int r;
    r = allow_noise ? $urandom_range(99) : $urandom_range(83);
    if (r < 70)
      send_request(hcbp_pkg::OP_ENCODE, alphabet[$urandom_range(15)], $urandom,
                   hcbp_pkg::LenW'($urandom));
    else if (r < 78)
      send_request(hcbp_pkg::OP_ENCODE, hcbp_pkg::SymW'($urandom_range(255)), $urandom,
                   hcbp_pkg::LenW'($urandom));
    else if (r < 84)
      send_request(hcbp_pkg::OP_FLUSH, hcbp_pkg::SymW'($urandom_range(255)), $urandom,
                   hcbp_pkg::LenW'($urandom));
    else if (r < 91)
      send_request(hcbp_pkg::OP_LOAD, alphabet[$urandom_range(15)], $urandom,
                   random_code_length());
    else if (r < 96)
      send_request(hcbp_pkg::OP_LOAD, hcbp_pkg::SymW'($urandom_range(255)), $urandom,
                   hcbp_pkg::LenW'($urandom));
    else
      send_request(hcbp_pkg::OP_NONE, hcbp_pkg::SymW'($urandom_range(255)), $urandom,
                   hcbp_pkg::LenW'($urandom));
  endtask

  task automatic test_reset_state();
    send_request(hcbp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_ENCODE, 8'h42, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_NONE, 8'h42, 32'h0, 6'd0);
  endtask

  task automatic test_directed_codes();
    send_request(hcbp_pkg::OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    send_request(hcbp_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_LOAD, 8'hFF, 32'h0F0F_0F0F, 6'd63);
    send_request(hcbp_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_LOAD, 8'h01, 32'h0000_0001, 6'd1);
    send_request(hcbp_pkg::OP_ENCODE, 8'h01, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_LOAD, 8'h02, 32'hFFFF_FFFD, 6'd3);
    send_request(hcbp_pkg::OP_ENCODE, 8'h02, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_LOAD, 8'h03, 32'hDEAD_BEEF, 6'd0);
    send_request(hcbp_pkg::OP_ENCODE, 8'h03, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_LOAD, 8'h04, 32'hAAAA_AAAA, 6'd33);
    send_request(hcbp_pkg::OP_ENCODE, 8'h01, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_ENCODE, 8'h04, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_LOAD, 8'h05, 32'hFFFF_FF7F, 6'd7);
    send_request(hcbp_pkg::OP_ENCODE, 8'h05, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_ENCODE, 8'h05, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_ENCODE, 8'h05, 32'h0, 6'd0);
    send_request(hcbp_pkg::OP_NONE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_request(hcbp_pkg::OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
  endtask

  task automatic test_steady_stream(input int n);
    gap_enable = 1'b0;
    stall_enable <= 1'b0;
    load_alphabet();
    for (int i = 0; i < n; i++) send_random_request(1'b0);
    gap_enable = 1'b1;
    stall_enable <= 1'b1;
  endtask

  task automatic test_random_stream(input int n);
    load_alphabet();
    for (int i = 0; i < n; i++) send_random_request(1'b1);
  endtask

  task automatic test_receiver_hold(input int n);
    alphabet[0] = hcbp_pkg::SymW'($urandom_range(255));
    send_request(hcbp_pkg::OP_LOAD, alphabet[0], $urandom, 6'd32);
    hold_cycles_left <= HoldCycles;
    for (int i = 0; i < n; i++)
      send_request(hcbp_pkg::OP_ENCODE, alphabet[0], $urandom, hcbp_pkg::LenW'($urandom));
  endtask

  task automatic test_drain_pause(input int rounds, input int n);
    for (int k = 0; k < rounds; k++) begin
      for (int i = 0; i < n; i++) send_random_request(1'b1);
      wait_for_drain();
    end
  endtask

  always @(posedge clk_i) begin : result_check
    packed_byte_t want;
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte", byte_if.out_byte, 0);
      end else begin
        want = pending_bytes.pop_front();
        if (byte_if.out_byte !== want.out_byte)
          report_mismatch("out_byte", byte_if.out_byte, want.out_byte);
        if (byte_if.last !== want.last)
          report_mismatch("last", byte_if.last, want.last);
      end
    end
    if (hold_cycles_left > 0) begin
      byte_if.ready    <= 1'b0;
      hold_cycles_left <= hold_cycles_left - 1;
    end else if (stall_enable && $urandom_range(99) < 19) begin
      byte_if.ready <= 1'b0;
    end else begin
      byte_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (byte_if.valid && byte_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t watchdog: no request or byte moved for %0d cycles", $realtime, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.opcode       = hcbp_pkg::OP_NONE;
    req_if.symbol       = '0;
    req_if.code_bits    = '0;
    req_if.code_length  = '0;
    byte_if.ready       = 1'b0;
    error_cnt           = 0;
    idle_cycles         = 0;
    hold_cycles_left    = 0;
    stall_enable        = 1'b1;
    gap_enable          = 1'b1;
    acc_byte            = '0;
    acc_fill            = 0;
    for (int i = 0; i < 256; i++) len_table[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_codes();
    test_steady_stream(60);
    test_random_stream(180);
    test_receiver_hold(40);
    test_drain_pause(4, 20);

    wait_for_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (error_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
